>>> src/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ssmm_pkg.sv
`default_nettype none

package ssmm_pkg;

	// Bus function of one request
	typedef enum logic [1:0] {
		FUNC_MEM_RD = 2'd0,
		FUNC_MEM_WR = 2'd1,
		FUNC_IO_IN  = 2'd2,
		FUNC_IO_OUT = 2'd3
	} func_t;

	// Device that serves the request
	typedef enum logic [3:0] {
		TGT_NONE     = 4'd0,
		TGT_BIOS     = 4'd1,
		TGT_CART     = 4'd2,
		TGT_EXP      = 4'd3,
		TGT_RAM      = 4'd4,
		TGT_SUB      = 4'd5,
		TGT_VDP_DATA = 4'd6,
		TGT_VDP_STAT = 4'd7,
		TGT_VDP_CTRL = 4'd8,
		TGT_PSG_RD   = 4'd9,
		TGT_PSG_SEL  = 4'd10,
		TGT_PSG_WR   = 4'd11,
		TGT_KBD_RD   = 4'd12,
		TGT_KBD_WR   = 4'd13
	} target_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAPPER_EN = 2'd0,
		CFG_SUB_ROM   = 2'd1
	} cfg_idx_t;

	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned TADDR_W = 22;
	localparam int unsigned DATA_W  = 8;
	localparam int unsigned OFS_W   = 14;

	localparam logic [ADDR_W-1:0] ADDR_SUBSLOT = 16'hFFFF;

	localparam logic [7:0] PORT_VDP_DATA = 8'h98;
	localparam logic [7:0] PORT_VDP_CTRL = 8'h99;
	localparam logic [7:0] PORT_PSG_SEL  = 8'hA0;
	localparam logic [7:0] PORT_PSG_WR   = 8'hA1;
	localparam logic [7:0] PORT_PSG_RD   = 8'hA2;
	localparam logic [7:0] PORT_SLOT     = 8'hA8;
	localparam logic [7:0] PORT_KBD_RD   = 8'hA9;
	localparam logic [7:0] PORT_KBD_WR   = 8'hAA;
	localparam logic [7:0] PORT_MAP_LO   = 8'hFC;
	localparam logic [7:0] PORT_MAP_HI   = 8'hFF;

	localparam logic [DATA_W-1:0] DATA_OPEN = 8'hFF;
	localparam logic [DATA_W-1:0] KBD_MASK  = 8'h0F;

	// Four 2-bit fields, one per page (or per subslot)
	typedef logic [3:0][1:0] quad_t;

	typedef struct packed {
		func_t             func;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
	} req_t;

	typedef struct packed {
		target_t            target;
		logic [TADDR_W-1:0] target_address;
		logic [DATA_W-1:0]  target_data;
		logic [DATA_W-1:0]  internal_data;
	} res_t;

	// Register contents seen by the decoder
	typedef struct packed {
		logic              mapper_enabled;
		logic              sub_rom_present;
		quad_t             prim;
		quad_t             sub_row;
		logic [DATA_W-1:0] seg;
	} view_t;

	// Register updates caused by one request
	typedef struct packed {
		logic              prim_we;
		logic              sub_we;
		logic              seg_we;
		logic [DATA_W-1:0] data;
	} upd_t;

endpackage

`default_nettype wire

>>> src/ssmm_regs.sv
`default_nettype none

module ssmm_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic                        cfg_data,
	input  wire logic                        upd_en,
	input  wire ssmm_pkg::upd_t              upd,
	input  wire logic [1:0]                  sub_idx,
	input  wire logic [1:0]                  seg_idx,
	output ssmm_pkg::view_t                  view
);

	logic                            mapper_en_q;
	logic                            sub_rom_q;
	ssmm_pkg::quad_t                 prim_q;
	ssmm_pkg::quad_t                 sub_q [4];
	logic [ssmm_pkg::DATA_W-1:0]     seg_q [4];

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_en_q <= 1'b0;
			sub_rom_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssmm_pkg::CFG_MAPPER_EN: mapper_en_q <= cfg_data;
				ssmm_pkg::CFG_SUB_ROM:   sub_rom_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Primary slot selects, subslot registers (one per slot), mapper segments
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_q <= '0;
			for (int i = 0; i < 4; i++) begin
				sub_q[i] <= '0;
				seg_q[i] <= '0;
			end
		end else if (upd_en) begin
			if (upd.prim_we)
				prim_q <= upd.data;
			if (upd.sub_we)
				sub_q[sub_idx] <= upd.data;
			if (upd.seg_we)
				seg_q[seg_idx] <= upd.data;
		end
	end

	always_comb begin
		view.mapper_enabled  = mapper_en_q;
		view.sub_rom_present = sub_rom_q;
		view.prim            = prim_q;
		view.sub_row         = sub_q[sub_idx];
		view.seg             = seg_q[seg_idx];
	end

endmodule

`default_nettype wire

>>> src/ssmm_decode.sv
`default_nettype none

module ssmm_decode (
	input  wire ssmm_pkg::req_t    req,
	input  wire ssmm_pkg::view_t   view,
	output logic [1:0]             sub_idx,
	output logic [1:0]             seg_idx,
	output ssmm_pkg::res_t         res,
	output ssmm_pkg::upd_t         upd
);

	logic [7:0]                      port;
	logic [1:0]                      page;
	logic [1:0]                      prim;
	logic [1:0]                      sec;
	logic                            is_io;
	logic [ssmm_pkg::TADDR_W-1:0]    ram_addr;
	logic [ssmm_pkg::TADDR_W-1:0]    plain_addr;

	assign port  = req.address[7:0];
	assign page  = req.address[15:14];
	assign prim  = view.prim[page];
	assign is_io = (req.func == ssmm_pkg::FUNC_IO_IN) || (req.func == ssmm_pkg::FUNC_IO_OUT);

	// Subslot row of the slot in this page; for FFFF that is page 3's slot
	assign sub_idx = prim;
	assign sec     = view.sub_row[page];
	assign seg_idx = is_io ? port[1:0] : page;

	assign plain_addr = {{(ssmm_pkg::TADDR_W - ssmm_pkg::ADDR_W){1'b0}}, req.address};
	assign ram_addr   = view.mapper_enabled ?
		{view.seg, req.address[ssmm_pkg::OFS_W-1:0]} : plain_addr;

	always_comb begin
		res.target         = ssmm_pkg::TGT_NONE;
		res.target_address = '0;
		res.target_data    = '0;
		res.internal_data  = '0;
		upd.prim_we        = 1'b0;
		upd.sub_we         = 1'b0;
		upd.seg_we         = 1'b0;
		upd.data           = req.data;

		case (req.func)
			ssmm_pkg::FUNC_MEM_RD: begin
				if (req.address == ssmm_pkg::ADDR_SUBSLOT) begin
					res.internal_data = ~view.sub_row;
				end else begin
					case (prim)
						2'd0: begin
							res.target         = ssmm_pkg::TGT_BIOS;
							res.target_address = plain_addr;
						end
						2'd1: begin
							res.target         = ssmm_pkg::TGT_CART;
							res.target_address = plain_addr;
						end
						2'd2: begin
							res.target         = ssmm_pkg::TGT_EXP;
							res.target_address = plain_addr;
						end
						default: begin
							// slot 3: RAM, optional sub ROM, rest open bus
							if (sec == 2'd0) begin
								res.target         = ssmm_pkg::TGT_RAM;
								res.target_address = ram_addr;
							end else if (sec == 2'd1 && view.sub_rom_present) begin
								res.target         = ssmm_pkg::TGT_SUB;
								res.target_address = plain_addr;
							end else begin
								res.internal_data = ssmm_pkg::DATA_OPEN;
							end
						end
					endcase
				end
			end
			ssmm_pkg::FUNC_MEM_WR: begin
				if (req.address == ssmm_pkg::ADDR_SUBSLOT) begin
					upd.sub_we = 1'b1;
				end else begin
					// BIOS slot ignores writes; slot 3 always hits RAM
					case (prim)
						2'd0: ;
						2'd1: begin
							res.target         = ssmm_pkg::TGT_CART;
							res.target_address = plain_addr;
							res.target_data    = req.data;
						end
						2'd2: begin
							res.target         = ssmm_pkg::TGT_EXP;
							res.target_address = plain_addr;
							res.target_data    = req.data;
						end
						default: begin
							res.target         = ssmm_pkg::TGT_RAM;
							res.target_address = ram_addr;
							res.target_data    = req.data;
						end
					endcase
				end
			end
			ssmm_pkg::FUNC_IO_IN: begin
				if (port == ssmm_pkg::PORT_VDP_DATA)
					res.target = ssmm_pkg::TGT_VDP_DATA;
				else if (port == ssmm_pkg::PORT_VDP_CTRL)
					res.target = ssmm_pkg::TGT_VDP_STAT;
				else if (port == ssmm_pkg::PORT_PSG_RD)
					res.target = ssmm_pkg::TGT_PSG_RD;
				else if (port == ssmm_pkg::PORT_KBD_RD)
					res.target = ssmm_pkg::TGT_KBD_RD;
				else if (port == ssmm_pkg::PORT_SLOT)
					res.internal_data = view.prim;
				else if (port inside {[ssmm_pkg::PORT_MAP_LO:ssmm_pkg::PORT_MAP_HI]})
					res.internal_data = view.mapper_enabled ? view.seg : ssmm_pkg::DATA_OPEN;
				else
					res.internal_data = ssmm_pkg::DATA_OPEN;
			end
			default: begin
				// io out
				if (port == ssmm_pkg::PORT_VDP_DATA) begin
					res.target      = ssmm_pkg::TGT_VDP_DATA;
					res.target_data = req.data;
				end else if (port == ssmm_pkg::PORT_VDP_CTRL) begin
					res.target      = ssmm_pkg::TGT_VDP_CTRL;
					res.target_data = req.data;
				end else if (port == ssmm_pkg::PORT_PSG_SEL) begin
					res.target      = ssmm_pkg::TGT_PSG_SEL;
					res.target_data = req.data;
				end else if (port == ssmm_pkg::PORT_PSG_WR) begin
					res.target      = ssmm_pkg::TGT_PSG_WR;
					res.target_data = req.data;
				end else if (port == ssmm_pkg::PORT_KBD_WR) begin
					res.target      = ssmm_pkg::TGT_KBD_WR;
					res.target_data = req.data & ssmm_pkg::KBD_MASK;
				end else if (port == ssmm_pkg::PORT_SLOT) begin
					upd.prim_we = 1'b1;
				end else if (port inside {[ssmm_pkg::PORT_MAP_LO:ssmm_pkg::PORT_MAP_HI]}) begin
					upd.seg_we = 1'b1;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/slot_select_memory_mapper_top.sv
// Slot select and memory mapper: decodes one CPU bus request per clock while
// out_ready is high. A request is taken into an input register, decoded
// against the slot, subslot and segment registers, and its result is
// registered in an output register. One request per cycle is sustained while
// out_ready stays high; register writes caused by a request (port A8, address
// FFFF, ports FC-FF) take effect at the same edge its result is registered,
// so the very next request already sees them. Results stall in the output
// register while out_ready is low, and the input register keeps taking one
// more request behind it. Config writes (cfg_we) apply at once and must only
// be issued while no request is in flight.
`default_nettype none

`include "assert_macros.svh"

module slot_select_memory_mapper_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// config write port
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic                              cfg_data,
	// request channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        func,
	input  wire logic [ssmm_pkg::ADDR_W-1:0]       address,
	input  wire logic [ssmm_pkg::DATA_W-1:0]       data,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [3:0]                             target,
	output logic [ssmm_pkg::TADDR_W-1:0]           target_address,
	output logic [ssmm_pkg::DATA_W-1:0]            target_data,
	output logic [ssmm_pkg::DATA_W-1:0]            internal_data
);

	logic               s1_valid_q;
	ssmm_pkg::req_t     req_s1;
	logic               out_valid_q;
	ssmm_pkg::res_t     res_q;
	logic               s1_adv;
	logic [1:0]         sub_idx;
	logic [1:0]         seg_idx;
	ssmm_pkg::view_t    view;
	ssmm_pkg::res_t     res;
	ssmm_pkg::upd_t     upd;
	logic               dev_out;
	logic               none_out;
	logic               int_clear;
	logic               fwd_clear;
	logic               slot_wr;

	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.func    <= ssmm_pkg::func_t'(func);
			req_s1.address <= address;
			req_s1.data    <= data;
		end
	end

	ssmm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.upd_en    (s1_adv),
		.upd       (upd),
		.sub_idx   (sub_idx),
		.seg_idx   (seg_idx),
		.view      (view)
	);

	ssmm_decode u_decode (
		.req     (req_s1),
		.view    (view),
		.sub_idx (sub_idx),
		.seg_idx (seg_idx),
		.res     (res),
		.upd     (upd)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign target         = res_q.target;
	assign target_address = res_q.target_address;
	assign target_data    = res_q.target_data;
	assign internal_data  = res_q.internal_data;

	// Terms for the checks
	assign dev_out   = out_valid_q && (res_q.target != ssmm_pkg::TGT_NONE);
	assign none_out  = out_valid_q && (res_q.target == ssmm_pkg::TGT_NONE);
	assign int_clear = (res_q.internal_data == '0);
	assign fwd_clear = (res_q.target_data == '0) && (res_q.target_address == '0);
	assign slot_wr   = s1_adv && (req_s1.func == ssmm_pkg::FUNC_IO_OUT) &&
		(req_s1.address[7:0] == ssmm_pkg::PORT_SLOT);

	// Checks
	`ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_ready, "input stalled with empty output")
	`ASSERT_NOW(a_internal_only_none, dev_out, int_clear, "internal data with a device target")
	`ASSERT_NOW(a_none_no_fwd, none_out, fwd_clear, "forwarded data with no target")
	`ASSERT_NEXT(a_slot_write, slot_wr, view.prim == $past(req_s1.data), "primary slot write lost")

endmodule

`default_nettype wire

>>> dv/slot_select_memory_mapper_top_test.sv
`timescale 1ns / 1ps

module slot_select_memory_mapper_top_test;

	// Slot numbers and subslot roles in the fixed machine layout
	localparam logic [1:0] SLOT_BIOS = 2'd0;
	localparam logic [1:0] SLOT_CART = 2'd1;
	localparam logic [1:0] SLOT_EXP  = 2'd2;
	localparam logic [1:0] SLOT_RAM  = 2'd3;
	localparam logic [1:0] SUB_RAM   = 2'd0;
	localparam logic [1:0] SUB_ROM   = 2'd1;

	// Register index with no register behind it
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 250;
	localparam int MAX_PRINTS   = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = '0;
	logic [15:0] address = '0;
	logic [7:0]  data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  target;
	logic [21:0] target_address;
	logic [7:0]  target_data;
	logic [7:0]  internal_data;

	slot_select_memory_mapper_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.address        (address),
		.data           (data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.target         (target),
		.target_address (target_address),
		.target_data    (target_data),
		.internal_data  (internal_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the decoder registers
	logic       map_en = 1'b0;
	logic       sub_rom_on = 1'b0;
	logic [1:0] slot_of_page [4] = '{default: '0};
	logic [1:0] subslot_tab [16] = '{default: '0};
	logic [7:0] segment [4] = '{default: '0};

	ssmm_pkg::res_t decoded_q [$];
	int   err_count = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_len = 0;
	int   hold_seq = 0;

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $time, msg);
		err_count++;
	endtask

	// Subslots of the slot that page 3 selects, packed two bits per page
	function automatic logic [7:0] subslot_row();
		logic [7:0] v;
		v = '0;
		for (int i = 0; i < 4; i++)
			v[2*i +: 2] = subslot_tab[{slot_of_page[3], i[1:0]}];
		return v;
	endfunction

	function automatic logic [21:0] ram_addr(input logic [15:0] a);
		if (!map_en)
			return {6'd0, a};
		return {segment[a[15:14]], a[13:0]};
	endfunction

	// Expected decode of one request; applies its register side effects
	function automatic ssmm_pkg::res_t decode_access(input ssmm_pkg::func_t f,
			input logic [15:0] a, input logic [7:0] d);
		ssmm_pkg::res_t r;
		logic [1:0] pg;
		logic [1:0] pr;
		logic [1:0] sc;
		logic [7:0] pt;
		r = '0;
		pg = a[15:14];
		pr = slot_of_page[pg];
		sc = subslot_tab[{pr, pg}];
		pt = a[7:0];
		case (f)
		ssmm_pkg::FUNC_MEM_RD: begin
			if (a == ssmm_pkg::ADDR_SUBSLOT) begin
				r.internal_data = ~subslot_row();
			end else if (pr == SLOT_BIOS) begin
				r.target = ssmm_pkg::TGT_BIOS;
				r.target_address = {6'd0, a};
			end else if (pr == SLOT_CART) begin
				r.target = ssmm_pkg::TGT_CART;
				r.target_address = {6'd0, a};
			end else if (pr == SLOT_EXP) begin
				r.target = ssmm_pkg::TGT_EXP;
				r.target_address = {6'd0, a};
			end else if (sc == SUB_RAM) begin
				r.target = ssmm_pkg::TGT_RAM;
				r.target_address = ram_addr(a);
			end else if (sc == SUB_ROM && sub_rom_on) begin
				r.target = ssmm_pkg::TGT_SUB;
				r.target_address = {6'd0, a};
			end else begin
				r.internal_data = ssmm_pkg::DATA_OPEN;
			end
		end
		ssmm_pkg::FUNC_MEM_WR: begin
			if (a == ssmm_pkg::ADDR_SUBSLOT) begin
				for (int i = 0; i < 4; i++)
					subslot_tab[{slot_of_page[3], i[1:0]}] = d[2*i +: 2];
			end else if (pr != SLOT_BIOS) begin
				r.target_data = d;
				if (pr == SLOT_CART) begin
					r.target = ssmm_pkg::TGT_CART;
					r.target_address = {6'd0, a};
				end else if (pr == SLOT_EXP) begin
					r.target = ssmm_pkg::TGT_EXP;
					r.target_address = {6'd0, a};
				end else begin
					// RAM slot takes writes whatever the subslot
					r.target = ssmm_pkg::TGT_RAM;
					r.target_address = ram_addr(a);
				end
			end
		end
		ssmm_pkg::FUNC_IO_IN: begin
			if (pt == ssmm_pkg::PORT_VDP_DATA) r.target = ssmm_pkg::TGT_VDP_DATA;
			else if (pt == ssmm_pkg::PORT_VDP_CTRL) r.target = ssmm_pkg::TGT_VDP_STAT;
			else if (pt == ssmm_pkg::PORT_PSG_RD) r.target = ssmm_pkg::TGT_PSG_RD;
			else if (pt == ssmm_pkg::PORT_KBD_RD) r.target = ssmm_pkg::TGT_KBD_RD;
			else if (pt == ssmm_pkg::PORT_SLOT) begin
				for (int i = 0; i < 4; i++)
					r.internal_data[2*i +: 2] = slot_of_page[i];
			end else if (pt >= ssmm_pkg::PORT_MAP_LO) begin
				r.internal_data = map_en ? segment[pt[1:0]] : ssmm_pkg::DATA_OPEN;
			end else begin
				r.internal_data = ssmm_pkg::DATA_OPEN;
			end
		end
		default: begin
			if (pt == ssmm_pkg::PORT_VDP_DATA) begin
				r.target = ssmm_pkg::TGT_VDP_DATA;
				r.target_data = d;
			end else if (pt == ssmm_pkg::PORT_VDP_CTRL) begin
				r.target = ssmm_pkg::TGT_VDP_CTRL;
				r.target_data = d;
			end else if (pt == ssmm_pkg::PORT_PSG_SEL) begin
				r.target = ssmm_pkg::TGT_PSG_SEL;
				r.target_data = d;
			end else if (pt == ssmm_pkg::PORT_PSG_WR) begin
				r.target = ssmm_pkg::TGT_PSG_WR;
				r.target_data = d;
			end else if (pt == ssmm_pkg::PORT_KBD_WR) begin
				r.target = ssmm_pkg::TGT_KBD_WR;
				r.target_data = d & ssmm_pkg::KBD_MASK;
			end else if (pt == ssmm_pkg::PORT_SLOT) begin
				for (int i = 0; i < 4; i++)
					slot_of_page[i] = d[2*i +: 2];
			end else if (pt >= ssmm_pkg::PORT_MAP_LO) begin
				segment[pt[1:0]] = d;
			end
		end
		endcase
		return r;
	endfunction

	// Offer one request, hold it until taken, then record its expected decode
	task automatic send_req(input ssmm_pkg::func_t f, input logic [15:0] a,
			input logic [7:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func <= f;
		address <= a;
		data <= d;
		do @(posedge clk); while (!in_ready);
		decoded_q.push_back(decode_access(f, a, d));
	endtask

	// Stop offering and wait until every request has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Back-to-back register writes; optionally also hits the unused index
	task automatic apply_config(input logic men, input logic srom, input logic poke_spare);
		cfg_we <= 1'b1;
		cfg_index <= ssmm_pkg::CFG_MAPPER_EN;
		cfg_data <= men;
		@(posedge clk);
		map_en = men;
		cfg_index <= ssmm_pkg::CFG_SUB_ROM;
		cfg_data <= srom;
		@(posedge clk);
		sub_rom_on = srom;
		if (poke_spare) begin
			cfg_index <= CFG_SPARE;
			cfg_data <= ~srom;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_port();
		case ($urandom_range(11))
		0:       return ssmm_pkg::PORT_VDP_DATA;
		1:       return ssmm_pkg::PORT_VDP_CTRL;
		2:       return ssmm_pkg::PORT_PSG_SEL;
		3:       return ssmm_pkg::PORT_PSG_WR;
		4:       return ssmm_pkg::PORT_PSG_RD;
		5, 6:    return ssmm_pkg::PORT_SLOT;
		7:       return ssmm_pkg::PORT_KBD_RD;
		8:       return ssmm_pkg::PORT_KBD_WR;
		9, 10:   return ssmm_pkg::PORT_MAP_LO | 8'($urandom_range(3));
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly meaningful requests: slot and segment setup, FFFF, page edges
	function automatic ssmm_pkg::req_t random_access();
		ssmm_pkg::req_t r;
		int unsigned pick;
		r.data = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 30) r.func = ssmm_pkg::FUNC_MEM_RD;
		else if (pick < 55) r.func = ssmm_pkg::FUNC_MEM_WR;
		else if (pick < 75) r.func = ssmm_pkg::FUNC_IO_IN;
		else r.func = ssmm_pkg::FUNC_IO_OUT;
		if (r.func == ssmm_pkg::FUNC_MEM_RD || r.func == ssmm_pkg::FUNC_MEM_WR) begin
			pick = $urandom_range(99);
			if (pick < 8) r.address = ssmm_pkg::ADDR_SUBSLOT;
			else if (pick < 14) r.address = {2'($urandom_range(3)), 14'h3FFF};
			else if (pick < 20) r.address = {2'($urandom_range(3)), 14'h0000};
			else r.address = 16'($urandom_range(16'hFFFF));
		end else begin
			r.address = {8'($urandom_range(255)), random_port()};
		end
		return r;
	endfunction

	task automatic send_random(input int count);
		ssmm_pkg::req_t r;
		for (int n = 0; n < count; n++) begin
			r = random_access();
			send_req(r.func, r.address, r.data);
		end
	endtask

	// Reset state, every slot and subslot path bar a present sub ROM, every port, special reads
	task automatic test_directed();
		send_req(ssmm_pkg::FUNC_MEM_RD, 16'h0000, 8'h00);
		send_req(ssmm_pkg::FUNC_MEM_WR, 16'h3FFF, 8'hA5);  // bios write dropped
		send_req(ssmm_pkg::FUNC_IO_OUT, 16'h00A8, 8'hE4);  // pages 0..3 -> slots 0..3
		send_req(ssmm_pkg::FUNC_IO_IN,  16'hFFA8, 8'h00);
		send_req(ssmm_pkg::FUNC_MEM_RD, 16'h4000, 8'h00);
		send_req(ssmm_pkg::FUNC_MEM_WR, 16'h7FFF, 8'hFF);
		send_req(ssmm_pkg::FUNC_MEM_RD, 16'hBFFF, 8'h00);
		send_req(ssmm_pkg::FUNC_MEM_WR, 16'hFFFF, 8'h1B);  // subslots of slot 3
		send_req(ssmm_pkg::FUNC_MEM_RD, 16'hFFFF, 8'h00);  // inverted readback
		send_req(ssmm_pkg::FUNC_MEM_RD, 16'hC000, 8'h00);
		send_req(ssmm_pkg::FUNC_IO_OUT, 16'h00A8, 8'hFF);  // all pages in slot 3
		send_req(ssmm_pkg::FUNC_MEM_WR, 16'h0000, 8'h5A);  // RAM even in subslot 3
		send_req(ssmm_pkg::FUNC_MEM_RD, 16'h0000, 8'h00);  // empty subslot
		send_req(ssmm_pkg::FUNC_MEM_RD, 16'h4000, 8'h00);
		send_req(ssmm_pkg::FUNC_MEM_RD, 16'h8000, 8'h00);  // sub ROM absent
		send_req(ssmm_pkg::FUNC_IO_OUT, 16'h00FF, 8'hFF);
		send_req(ssmm_pkg::FUNC_IO_IN,  16'h00FE, 8'h00);  // mapper off reads open bus
		send_req(ssmm_pkg::FUNC_IO_IN,  16'h0098, 8'h00);
		send_req(ssmm_pkg::FUNC_IO_IN,  16'hFF99, 8'h00);
		send_req(ssmm_pkg::FUNC_IO_IN,  16'h00A2, 8'h00);
		send_req(ssmm_pkg::FUNC_IO_IN,  16'h00A9, 8'h00);
		send_req(ssmm_pkg::FUNC_IO_OUT, 16'h0098, 8'hFF);
		send_req(ssmm_pkg::FUNC_IO_OUT, 16'h0099, 8'h00);
		send_req(ssmm_pkg::FUNC_IO_OUT, 16'h00A0, 8'h81);
		send_req(ssmm_pkg::FUNC_IO_OUT, 16'h00A1, 8'h7E);
		send_req(ssmm_pkg::FUNC_IO_OUT, 16'h00AA, 8'hFF);
		send_req(ssmm_pkg::FUNC_IO_IN,  16'h0000, 8'h00);  // unknown port
		send_req(ssmm_pkg::FUNC_IO_OUT, 16'hFF00, 8'h55);
	endtask

	// Every register setting against mapper readback, sub ROM and RAM mapping
	task automatic test_config_regs();
		logic [1:0] c;
		for (int k = 0; k < 4; k++) begin
			c = k[1:0];
			drain_results();
			apply_config(c[0], c[1], k == 3);
			send_req(ssmm_pkg::FUNC_IO_OUT, 16'h00FC, 8'(8'h80 | k));
			send_req(ssmm_pkg::FUNC_IO_IN,  16'h00FC, 8'h00);
			send_req(ssmm_pkg::FUNC_IO_IN,  16'h00FF, 8'h00);
			send_req(ssmm_pkg::FUNC_MEM_RD, 16'h8123, 8'h00);
			send_req(ssmm_pkg::FUNC_MEM_RD, 16'hFFFE, 8'h00);
			send_req(ssmm_pkg::FUNC_MEM_WR, 16'h3ABC, 8'hC3);
		end
	endtask

	// Receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		drain_results();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = HOLD_CYCLES;
		hold_seq++;
		send_random(40);
	endtask

	// Sender pauses until everything outstanding has come back
	task automatic test_drain_pause();
		send_idle_pct = 20;
		recv_stall_pct = 20;
		send_random(20);
		drain_results();
		send_random(20);
	endtask

	task automatic test_random_phases();
		int send_pct [4] = '{0, 68, 0, 6};
		int recv_pct [4] = '{0, 0, 68, 6};
		logic [1:0] cfg;
		for (int p = 0; p < 4; p++) begin
			drain_results();
			cfg = 2'(p * 3) ^ 2'(p >> 1);
			apply_config(cfg[0], cfg[1], 1'b0);
			send_idle_pct = send_pct[p];
			recv_stall_pct = recv_pct[p];
			send_random(PHASE_ITEMS);
		end
	endtask

	// Receiver: random stalls plus an occasional long hold-off
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each returned decode with the oldest expectation
	always @(posedge clk) begin
		ssmm_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = decoded_q.pop_front();
				if (target !== want.target)
					report_mismatch($sformatf("target %0d, want %0d", target, want.target));
				if (target_address !== want.target_address)
					report_mismatch($sformatf("target_address %h, want %h",
						target_address, want.target_address));
				if (target_data !== want.target_data)
					report_mismatch($sformatf("target_data %h, want %h",
						target_data, want.target_data));
				if (internal_data !== want.internal_data)
					report_mismatch($sformatf("internal_data %h, want %h",
						internal_data, want.internal_data));
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_regs();
		test_backpressure();
		test_drain_pause();
		test_random_phases();
		drain_results();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/ssmm_pkg.sv
src/ssmm_regs.sv
src/ssmm_decode.sv
src/slot_select_memory_mapper_top.sv
dv/slot_select_memory_mapper_top_test.sv
